### hdl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared constants and types for the motor response frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam logic [7:0] TAIL_BYTE = 8'h6B;
  localparam logic [7:0] CODE_VEL  = 8'h35;
  localparam logic [7:0] CODE_POS  = 8'h36;
  localparam logic [7:0] CODE_PERR = 8'h37;
  localparam logic [7:0] CODE_FLAG = 8'h3A;
  localparam logic [7:0] CODE_HOME = 8'h3B;

  localparam logic [2:0] KIND_TAIL_ERR = 3'd0;
  localparam logic [2:0] KIND_VEL      = 3'd1;
  localparam logic [2:0] KIND_POS      = 3'd2;
  localparam logic [2:0] KIND_PERR     = 3'd3;
  localparam logic [2:0] KIND_FLAG     = 3'd4;
  localparam logic [2:0] KIND_HOME     = 3'd5;
  localparam logic [2:0] KIND_ACK      = 3'd6;
  localparam logic [2:0] KIND_UNK      = 3'd7;

  localparam logic [3:0] LEN_FLAG       = 4'd4;
  localparam logic [3:0] LEN_VEL        = 4'd5;
  localparam logic [3:0] LEN_POS        = 4'd7;
  localparam logic [3:0] BYTE_COUNT_MAX = 4'd8;
  localparam logic [3:0] MIN_BYTES_HELD = 4'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic        valid;
    logic [31:0] value;
    logic [4:0]  flags;
    logic [2:0]  rsv;
    logic        tail_ok;
    logic        odd;
  } class_t;

endpackage

### hdl/motor_response_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_response_frame_parser
// Parses stepper-drive response frames byte by byte into decoded results.
// ----------------------------------------------------------------------------
// Input stream: one frame byte per beat in s_axis_tdata, s_axis_tlast on the
// final byte. s_axis_tuser high makes the beat a clear command that zeroes
// the five statistics counters; its data and last mark are ignored.
// Output stream: one beat at the end of every frame of three or more bytes,
// carrying address, kind, validity, payload and the counters after counting.
// Shorter frames and clear commands give no output beat.
// A frame's last byte is taken into the input register, and its result then
// goes into the result register.
// Throughput: one byte per cycle while the receiver does not stall.
// Reset clears the frame state, the counters and both valid registers.
// When the receiver stalls the result register holds; the input register
// still takes a byte, and s_axis_tready drops only once both are full.
// ----------------------------------------------------------------------------
module motor_response_frame_parser import mrfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive_addr[7:0], value[39:8], status_flags[44:40], reserved_bits[47:45],
  // total_count[79:48], tail_error_count[111:80], unknown_count[143:112],
  // valid_count[175:144], invalid_count[207:176]
  output logic [207:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser    // frame_kind[2:0], valid_res[3]
);

  logic        s1_valid;
  logic        s1_cmd;
  logic [7:0]  s1_byte;
  logic        s1_last;

  logic [3:0]  byte_count;
  logic [7:0]  addr_reg;
  logic [7:0]  func_reg;
  logic [31:0] payload_shift;

  logic [31:0] cnt_total, cnt_tail, cnt_unk, cnt_valid, cnt_invalid;

  logic        out_valid;
  logic [7:0]  out_addr;
  logic [2:0]  out_kind;
  logic        out_vres;
  logic [31:0] out_value;
  logic [4:0]  out_flags;
  logic [2:0]  out_rsv;

  logic        adv2;
  logic        proc;
  logic        emit;
  class_t      cls;

  assign adv2          = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || adv2;
  assign proc          = s1_valid && adv2;
  assign emit          = !s1_cmd && s1_last && (byte_count >= MIN_BYTES_HELD);

  mrfp_classify u_classify (
    .fcode     (func_reg),
    .frame_len (byte_count + 4'd1),
    .tail      (s1_byte),
    .payload   (payload_shift),
    .res       (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      s1_cmd  <= s_axis_tuser;
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      addr_reg      <= '0;
      func_reg      <= '0;
      payload_shift <= '0;
      cnt_total     <= '0;
      cnt_tail      <= '0;
      cnt_unk       <= '0;
      cnt_valid     <= '0;
      cnt_invalid   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (adv2) begin
        out_valid <= proc && emit;
      end
      if (proc) begin
        if (s1_cmd) begin
          cnt_total   <= '0;
          cnt_tail    <= '0;
          cnt_unk     <= '0;
          cnt_valid   <= '0;
          cnt_invalid <= '0;
        end else if (!s1_last) begin
          if (byte_count == 4'd0) begin
            addr_reg <= s1_byte;
          end else if (byte_count == 4'd1) begin
            func_reg <= s1_byte;
          end else begin
            payload_shift <= {payload_shift[23:0], s1_byte};
          end
          if (byte_count < BYTE_COUNT_MAX) begin
            byte_count <= byte_count + 4'd1;
          end
        end else begin
          if (emit) begin
            cnt_total   <= cnt_total + 32'd1;
            cnt_tail    <= cnt_tail + {31'd0, !cls.tail_ok};
            cnt_unk     <= cnt_unk + {31'd0, cls.odd};
            cnt_valid   <= cnt_valid + {31'd0, cls.tail_ok && cls.valid};
            cnt_invalid <= cnt_invalid + {31'd0, cls.tail_ok && !cls.valid};
          end
          byte_count    <= '0;
          addr_reg      <= '0;
          func_reg      <= '0;
          payload_shift <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_addr  <= addr_reg;
      out_kind  <= cls.kind;
      out_vres  <= cls.valid;
      out_value <= cls.value;
      out_flags <= cls.flags;
      out_rsv   <= cls.rsv;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_vres, out_kind};
  assign m_axis_tdata  = {cnt_invalid, cnt_valid, cnt_unk, cnt_tail, cnt_total,
                          out_rsv, out_flags, out_value, out_addr};

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= BYTE_COUNT_MAX)
    else $error("byte count beyond saturation");

  a_tail_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_TAIL_ERR) |-> !out_vres && (out_value == 32'd0))
    else $error("tail error result carries data");

  a_odd_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_HOME || out_kind == KIND_UNK) |-> !out_vres)
    else $error("homing or unknown frame marked valid");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    proc && s1_cmd |=> (cnt_total == 32'd0) && (cnt_valid == 32'd0)
                       && (cnt_invalid == 32'd0))
    else $error("counters not cleared");

  a_frame_reset: assert property (@(posedge clk) disable iff (rst)
    proc && !s1_cmd && s1_last |=> (byte_count == 4'd0))
    else $error("frame state kept after last byte");

endmodule

### hdl/mrfp_classify.sv
// ----------------------------------------------------------------------------
// mrfp_classify
// Tail check, function code decode and payload extraction for one frame.
// ----------------------------------------------------------------------------
module mrfp_classify import mrfp_pkg::*; (
  input  logic [7:0]  fcode,
  input  logic [3:0]  frame_len,
  input  logic [7:0]  tail,
  input  logic [31:0] payload,
  output class_t      res
);

  always_comb begin
    res         = '0;
    res.kind    = KIND_TAIL_ERR;
    res.tail_ok = (tail == TAIL_BYTE);
    if (res.tail_ok) begin
      case (fcode)
        CODE_VEL: begin
          res.kind = KIND_VEL;
          if (frame_len == LEN_VEL) begin
            res.value = {{16{payload[15]}}, payload[15:0]};
            res.valid = 1'b1;
          end
        end
        CODE_POS: begin
          res.kind = KIND_POS;
          if (frame_len == LEN_POS) begin
            res.value = payload;
            res.valid = 1'b1;
          end
        end
        CODE_PERR: begin
          res.kind = KIND_PERR;
          if (frame_len == LEN_POS) begin
            res.value = payload;
            res.valid = 1'b1;
          end
        end
        CODE_FLAG: begin
          res.kind = KIND_FLAG;
          if (frame_len == LEN_FLAG) begin
            res.flags = payload[4:0];
            res.rsv   = payload[7:5];
            res.valid = 1'b1;
          end
        end
        CODE_HOME: begin
          res.kind = KIND_HOME;
          res.odd  = 1'b1;
        end
        default: begin
          if (frame_len == LEN_FLAG) begin
            res.kind  = KIND_ACK;
            res.valid = 1'b1;
          end else begin
            res.kind = KIND_UNK;
            res.odd  = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
